// ===== rtl/core/hkv_pkg.sv =====
// Shared types, constants and default parameters of the hashed key/value map.
package hkv_pkg;

  localparam int unsigned BUCKETS_DEF = 256;
  localparam int unsigned WAYS_DEF    = 4;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SLOT_W  = KEY_W + 1;
  localparam int unsigned COUNT_W = 11;

  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam int unsigned HASH_SHIFT = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] prev_value;
    logic             full;
    logic             grow;
    logic             shrink;
  } match_res_t;

endpackage

// ===== rtl/core/hkv_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module hkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/hkv_hash.sv =====
// Multi-cycle djb2-xor hash of a key and its reduction to a bucket index.
module hkv_hash #(
  parameter int unsigned BUCKETS = hkv_pkg::BUCKETS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hkv_pkg::KEY_W-1:0]  key_i,
  output logic                       done_o,
  output logic [$clog2(BUCKETS)-1:0] bucket_o
);

  localparam int unsigned RW      = $clog2(BUCKETS);
  localparam bit          IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [RW:0] BMOD    = (RW + 1)'(BUCKETS);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_STEP = 2'd1;
  localparam logic [1:0] H_MOD  = 2'd2;
  localparam logic [1:0] H_DONE = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [31:0]   h_q, h_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [7:0]    byte_sel;
  logic [31:0]   h_step;
  logic [RW-1:0] rem_step;

  assign byte_sel = key_i[{cnt_q[1:0], 3'b000} +: 8];
  assign h_step   = ((h_q << hkv_pkg::HASH_SHIFT) + h_q) ^ {24'b0, byte_sel};

  // Four bits of the hash, most significant first, per cycle.
  always_comb begin
    logic [RW:0] t;
    t = {1'b0, rem_q};
    for (int i = 3; i >= 0; i--) begin
      t = {t[RW-1:0], h_q[28+i]};
      if (t >= BMOD) begin
        t = t - BMOD;
      end
    end
    rem_step = t[RW-1:0];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    h_d     = h_q;
    rem_d   = rem_q;
    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          h_d     = hkv_pkg::HASH_SEED;
          cnt_d   = 3'd0;
          state_d = H_STEP;
        end
      end
      H_STEP: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          h_d     = (h_step == 32'd0) ? 32'd1 : h_step;
          rem_d   = '0;
          cnt_d   = 3'd0;
          state_d = IS_POW2 ? H_DONE : H_MOD;
        end else begin
          h_d = h_step;
        end
      end
      H_MOD: begin
        rem_d = rem_step;
        h_d   = h_q << 4;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = H_DONE;
        end
      end
      H_DONE: begin
        state_d = H_IDLE;
      end
      default: begin
        state_d = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    rem_q <= rem_d;
  end

  assign done_o   = (state_q == H_DONE);
  assign bucket_o = IS_POW2 ? h_q[RW-1:0] : rem_q;

endmodule

// ===== rtl/core/hkv_match.sv =====
// Way search of one bucket row and the modified rows to write back.
module hkv_match #(
  parameter int unsigned WAYS = hkv_pkg::WAYS_DEF
) (
  input  hkv_pkg::op_e                        op_i,
  input  logic [hkv_pkg::KEY_W-1:0]           key_i,
  input  logic [hkv_pkg::VAL_W-1:0]           value_i,
  input  logic [WAYS*hkv_pkg::SLOT_W-1:0]     key_row_i,
  input  logic [WAYS*hkv_pkg::VAL_W-1:0]      val_row_i,
  output logic [WAYS*hkv_pkg::SLOT_W-1:0]     key_row_o,
  output logic [WAYS*hkv_pkg::VAL_W-1:0]      val_row_o,
  output hkv_pkg::match_res_t                 res_o
);

  localparam int unsigned SW = hkv_pkg::SLOT_W;
  localparam int unsigned VW = hkv_pkg::VAL_W;

  logic            have_hit, have_free;
  logic [WAYS-1:0] hit_sel, free_sel;
  logic [VW-1:0]   prev_value;

  always_comb begin
    have_hit  = 1'b0;
    have_free = 1'b0;
    hit_sel   = '0;
    free_sel  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!key_row_i[w*SW + SW - 1]) begin
        if (!have_free) begin
          free_sel[w] = 1'b1;
          have_free   = 1'b1;
        end
      end else if (!have_hit && key_row_i[w*SW +: hkv_pkg::KEY_W] == key_i) begin
        hit_sel[w] = 1'b1;
        have_hit   = 1'b1;
      end
    end
  end

  always_comb begin
    key_row_o  = key_row_i;
    val_row_o  = val_row_i;
    prev_value = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_sel[w]) begin
        prev_value = val_row_i[w*VW +: VW];
      end
      unique case (op_i)
        hkv_pkg::OP_INSERT: begin
          if (hit_sel[w]) begin
            val_row_o[w*VW +: VW] = value_i;
          end else if (!have_hit && free_sel[w]) begin
            key_row_o[w*SW +: SW] = {1'b1, key_i};
            val_row_o[w*VW +: VW] = value_i;
          end
        end
        hkv_pkg::OP_REMOVE: begin
          if (hit_sel[w]) begin
            key_row_o[w*SW + SW - 1] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o.found      = have_hit;
    res_o.prev_value = prev_value;
    res_o.full       = (op_i == hkv_pkg::OP_INSERT) && !have_hit && !have_free;
    res_o.grow       = (op_i == hkv_pkg::OP_INSERT) && !have_hit && have_free;
    res_o.shrink     = (op_i == hkv_pkg::OP_REMOVE) && have_hit;
  end

endmodule

// ===== rtl/core/hashed_key_value_map.sv =====
// A request passes the byte-serial hash (and the remainder when BUCKETS is not a power of two),
// a registered read of the bucket row and the way match; one request is handled at a time.
// A clear request walks every bucket row of the key RAM, and its result follows that walk.
// After reset the same walk clears all valid bits; requests wait until it ends.
// The reset is asynchronous and active low; a result waiting at the output does not stop acceptance.
module hashed_key_value_map #(
  parameter int unsigned BUCKETS = hkv_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS    = hkv_pkg::WAYS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [hkv_pkg::KEY_W-1:0]     key_i,
  input  logic [hkv_pkg::VAL_W-1:0]     new_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [hkv_pkg::VAL_W-1:0]     old_value_o,
  output logic                          status_o,
  output logic [hkv_pkg::COUNT_W-1:0]   entry_count_o
);

  localparam int unsigned RW     = $clog2(BUCKETS);
  localparam int unsigned CW     = $clog2(BUCKETS * WAYS + 1);
  localparam int unsigned KROW_W = WAYS * hkv_pkg::SLOT_W;
  localparam int unsigned VROW_W = WAYS * hkv_pkg::VAL_W;
  localparam logic [RW-1:0] LAST_ROW = RW'(BUCKETS - 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_CLRD = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [RW-1:0]                sweep_q, sweep_d;
  logic [CW-1:0]                count_q, count_d;
  hkv_pkg::op_e                 op_q, op_d;
  logic [hkv_pkg::KEY_W-1:0]    key_q, key_d;
  logic [hkv_pkg::VAL_W-1:0]    val_q, val_d;
  logic [RW-1:0]                bucket_q, bucket_d;
  logic                         out_valid_q, out_valid_d;
  logic                         found_q, found_d;
  logic [hkv_pkg::VAL_W-1:0]    old_q, old_d;
  logic                         status_q, status_d;
  logic [hkv_pkg::COUNT_W-1:0]  entry_q, entry_d;

  logic                         out_free, accept, produce, hash_start, commit, sweeping;
  logic                         hash_done;
  logic [RW-1:0]                hash_bucket;
  logic [KROW_W-1:0]            key_row_rd, key_row_wr, key_wdata;
  logic [VROW_W-1:0]            val_row_rd, val_row_wr;
  logic [RW-1:0]                key_waddr;
  logic [CW-1:0]                count_next;
  hkv_pkg::match_res_t          res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == S_CMP) && out_free;
  assign sweeping   = (state_q == S_INIT) || (state_q == S_CLR);
  assign in_stall_o = !((state_q == S_IDLE) || commit);
  assign accept     = in_valid_i && !in_stall_o;

  hkv_hash #(
    .BUCKETS(BUCKETS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_q),
    .done_o  (hash_done),
    .bucket_o(hash_bucket)
  );

  assign key_waddr = sweeping ? sweep_q : bucket_q;
  assign key_wdata = sweeping ? '0 : key_row_wr;

  hkv_ram #(
    .WIDTH(KROW_W),
    .DEPTH(BUCKETS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (sweeping || commit),
    .waddr_i(key_waddr),
    .wdata_i(key_wdata),
    .re_i   (hash_done),
    .raddr_i(hash_bucket),
    .rdata_o(key_row_rd)
  );

  hkv_ram #(
    .WIDTH(VROW_W),
    .DEPTH(BUCKETS)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (commit),
    .waddr_i(bucket_q),
    .wdata_i(val_row_wr),
    .re_i   (hash_done),
    .raddr_i(hash_bucket),
    .rdata_o(val_row_rd)
  );

  hkv_match #(
    .WAYS(WAYS)
  ) u_match (
    .op_i     (op_q),
    .key_i    (key_q),
    .value_i  (val_q),
    .key_row_i(key_row_rd),
    .val_row_i(val_row_rd),
    .key_row_o(key_row_wr),
    .val_row_o(val_row_wr),
    .res_o    (res)
  );

  always_comb begin
    count_next = count_q;
    if (res.grow) begin
      count_next = count_q + CW'(1);
    end else if (res.shrink) begin
      count_next = count_q - CW'(1);
    end
  end

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    count_d    = count_q;
    op_d       = op_q;
    key_d      = key_q;
    val_d      = val_q;
    bucket_d   = bucket_q;
    found_d    = found_q;
    old_d      = old_q;
    status_d   = status_q;
    entry_d    = entry_q;
    produce    = 1'b0;
    hash_start = 1'b0;
    unique case (state_q)
      S_INIT: begin
        sweep_d = sweep_q + RW'(1);
        if (sweep_q == LAST_ROW) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
      end
      S_HASH: begin
        if (hash_done) begin
          bucket_d = hash_bucket;
          state_d  = S_CMP;
        end
      end
      S_CMP: begin
        if (out_free) begin
          produce  = 1'b1;
          found_d  = res.found;
          old_d    = res.prev_value;
          status_d = res.full;
          count_d  = count_next;
          entry_d  = hkv_pkg::COUNT_W'(count_next);
          state_d  = S_IDLE;
        end
      end
      S_CLR: begin
        sweep_d = sweep_q + RW'(1);
        if (sweep_q == LAST_ROW) begin
          state_d = S_CLRD;
        end
      end
      S_CLRD: begin
        if (out_free) begin
          produce  = 1'b1;
          found_d  = 1'b0;
          old_d    = '0;
          status_d = 1'b0;
          count_d  = '0;
          entry_d  = '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (accept) begin
      op_d  = hkv_pkg::op_e'(operation_i);
      key_d = key_i;
      val_d = new_value_i;
      if (hkv_pkg::op_e'(operation_i) == hkv_pkg::OP_CLEAR) begin
        sweep_d = '0;
        state_d = S_CLR;
      end else begin
        hash_start = 1'b1;
        state_d    = S_HASH;
      end
    end
  end

  assign out_valid_d = produce || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sweep_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    val_q    <= val_d;
    bucket_q <= bucket_d;
    found_q  <= found_d;
    old_q    <= old_d;
    status_q <= status_d;
    entry_q  <= entry_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign old_value_o   = old_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_q;

endmodule

// ===== rtl/core/hkv_checker.sv =====
// Port-level assertions of the hashed key/value map and their binding to the top level.
module hkv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          found_o,
  input logic [hkv_pkg::VAL_W-1:0]     old_value_o,
  input logic                          status_o,
  input logic [hkv_pkg::COUNT_W-1:0]   entry_count_o
);

  // Only one request is in flight, so the block is busy in the cycle after an acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while the previous one was still in flight");

  // A refused insert reports neither a hit nor an old value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !found_o && old_value_o == '0)
    else $error("full-bucket status together with a hit");

  // A miss always carries a zero old value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> old_value_o == '0)
    else $error("old value not zero on a miss");

  // A stalled result stays valid and holds its entry count and old value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_count_o) && $stable(old_value_o))
    else $error("stalled result changed");

endmodule

bind hashed_key_value_map hkv_checker u_hkv_checker (.*);

// ===== bench/hashed_key_value_map_test.sv =====
// Self-checking testbench for the hashed key/value map, with a mirror of the table as predictor.
`timescale 1ns / 100ps

module hashed_key_value_map_test;

  localparam int unsigned NBUCKETS        = hkv_pkg::BUCKETS_DEF;
  localparam int unsigned NWAYS           = hkv_pkg::WAYS_DEF;
  localparam int unsigned NSLOTS          = NBUCKETS * NWAYS;
  localparam int unsigned RANDOM_REQUESTS = 840;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned GROUPS          = 6;
  localparam int unsigned GROUP_KEYS      = 6;
  localparam int unsigned RECENT_DEPTH    = 64;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef struct packed {
    logic                        found;
    logic [hkv_pkg::VAL_W-1:0]   prev_value;
    logic                        status;
    logic [hkv_pkg::COUNT_W-1:0] entry_count;
  } map_result_t;

  class kv_map_mirror;
    bit                      slot_used[NSLOTS];
    bit [hkv_pkg::KEY_W-1:0] slot_key[NSLOTS];
    bit [hkv_pkg::VAL_W-1:0] slot_value[NSLOTS];
    int unsigned             used_entries;
    map_result_t             pending_results[$];
    int unsigned             result_mismatches;

    function bit [31:0] raw_hash(bit [hkv_pkg::KEY_W-1:0] key);
      bit [31:0] h;
      h = hkv_pkg::HASH_SEED;
      for (int i = 0; i < 4; i++) begin
        h = ((h << hkv_pkg::HASH_SHIFT) + h) ^ {24'd0, key[8*i +: 8]};
      end
      return h;
    endfunction

    function int unsigned bucket_of(bit [hkv_pkg::KEY_W-1:0] key);
      bit [31:0] h;
      h = raw_hash(key);
      if (h == 32'd0) begin
        h = 32'd1;
      end
      return h % NBUCKETS;
    endfunction

    function void note_request(hkv_pkg::op_e op, bit [hkv_pkg::KEY_W-1:0] key,
                               bit [hkv_pkg::VAL_W-1:0] value);
      map_result_t want;
      int          base;
      int          hit;
      int          free_slot;
      want      = '0;
      hit       = -1;
      free_slot = -1;
      if (op == hkv_pkg::OP_CLEAR) begin
        foreach (slot_used[s]) slot_used[s] = 1'b0;
        used_entries = 0;
      end else begin
        base = bucket_of(key) * NWAYS;
        for (int w = 0; w < NWAYS; w++) begin
          if (!slot_used[base + w]) begin
            if (free_slot < 0) free_slot = base + w;
          end else if (hit < 0 && slot_key[base + w] == key) begin
            hit = base + w;
          end
        end
        if (hit >= 0) begin
          want.found      = 1'b1;
          want.prev_value = slot_value[hit];
        end
        if (op == hkv_pkg::OP_INSERT) begin
          if (hit >= 0) begin
            slot_value[hit] = value;
          end else if (free_slot >= 0) begin
            slot_used[free_slot]  = 1'b1;
            slot_key[free_slot]   = key;
            slot_value[free_slot] = value;
            used_entries++;
          end else begin
            want.status = 1'b1;
          end
        end else if (op == hkv_pkg::OP_REMOVE && hit >= 0) begin
          slot_used[hit] = 1'b0;
          used_entries--;
        end
      end
      want.entry_count = used_entries[hkv_pkg::COUNT_W-1:0];
      pending_results.push_back(want);
    endfunction

    function void check_result(map_result_t got);
      map_result_t want;
      if (pending_results.size() == 0) begin
        result_mismatches++;
        if (result_mismatches <= REPORT_LIMIT) begin
          $display("Unexpected result: found=%0d old=%h status=%0d count=%0d",
                   got.found, got.prev_value, got.status, got.entry_count);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.found !== want.found || got.prev_value !== want.prev_value ||
          got.status !== want.status || got.entry_count !== want.entry_count) begin
        result_mismatches++;
        if (result_mismatches <= REPORT_LIMIT) begin
          $write("Mismatch: expected found=%0d old=%h status=%0d count=%0d, ",
                 want.found, want.prev_value, want.status, want.entry_count);
          $display("got found=%0d old=%h status=%0d count=%0d",
                   got.found, got.prev_value, got.status, got.entry_count);
        end
      end
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic [1:0]                  operation_i = 2'd0;
  logic [hkv_pkg::KEY_W-1:0]   key_i       = '0;
  logic [hkv_pkg::VAL_W-1:0]   new_value_i = '0;
  logic                        out_stall_i = 1'b0;
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic                        found_o;
  logic [hkv_pkg::VAL_W-1:0]   old_value_o;
  logic                        status_o;
  logic [hkv_pkg::COUNT_W-1:0] entry_count_o;

  kv_map_mirror                map_model = new;
  int unsigned                 send_idle_pct = 9;
  int unsigned                 recv_idle_pct = 45;
  logic                        hold_go = 1'b0;
  int unsigned                 hold_count = 0;
  bit [hkv_pkg::KEY_W-1:0]     group_keys[GROUPS*GROUP_KEYS];
  bit [hkv_pkg::KEY_W-1:0]     recent_keys[$];

  hashed_key_value_map #(
    .BUCKETS(NBUCKETS),
    .WAYS   (NWAYS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .key_i        (key_i),
    .new_value_i  (new_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .old_value_o  (old_value_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_go && hold_count < HOLD_CYCLES) begin
      out_stall_i <= 1'b1;
      hold_count  <= hold_count + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      map_model.check_result({found_o, old_value_o, status_o, entry_count_o});
    end
  end

  task automatic send_request(hkv_pkg::op_e op, bit [hkv_pkg::KEY_W-1:0] key,
                              bit [hkv_pkg::VAL_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    new_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    map_model.note_request(op, key, value);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (map_model.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_request();
    hkv_pkg::op_e            op;
    bit [hkv_pkg::KEY_W-1:0] key;
    bit [hkv_pkg::VAL_W-1:0] value;
    int unsigned             pick;
    pick = $urandom_range(99);
    op = (pick < 45) ? hkv_pkg::OP_INSERT :
         (pick < 65) ? hkv_pkg::OP_REMOVE :
         (pick < 97) ? hkv_pkg::OP_LOOKUP : hkv_pkg::OP_CLEAR;
    pick = $urandom_range(99);
    if (pick < 45) begin
      key = group_keys[$urandom_range(GROUPS*GROUP_KEYS-1)];
    end else if (pick < 80 && recent_keys.size() != 0) begin
      key = recent_keys[$urandom_range(recent_keys.size()-1)];
    end else begin
      key = $urandom;
    end
    value = $urandom;
    pick = $urandom_range(19);
    if (pick == 0) begin
      value = '0;
    end else if (pick == 1) begin
      value = '1;
    end
    if (op == hkv_pkg::OP_INSERT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
    end
    send_request(op, key, value);
  endtask

  initial begin
    bit [15:0]               low_bytes[bit [31:0]];
    bit [31:0]               inv33;
    bit [31:0]               h;
    bit [hkv_pkg::KEY_W-1:0] zero_key;
    bit                      zero_found;
    bit [hkv_pkg::KEY_W-1:0] k;
    bit [hkv_pkg::KEY_W-1:0] fill_keys[$];
    int unsigned             per_bucket[NBUCKETS];
    int unsigned             target;
    int unsigned             filled;

    // Keys that share a bucket, so that buckets fill up and ways get reused.
    for (int g = 0; g < GROUPS; g++) begin
      target = (g == 0) ? 0 : (g == 1) ? 1 :
               (g == 2) ? NBUCKETS - 1 : $urandom_range(NBUCKETS-1);
      filled = 0;
      while (filled < GROUP_KEYS) begin
        k = $urandom;
        if (map_model.bucket_of(k) == target) begin
          group_keys[g*GROUP_KEYS + filled] = k;
          filled++;
        end
      end
    end

    // Meet in the middle for a key whose raw hash is zero, if one exists.
    for (int lo = 0; lo < 65536; lo++) begin
      h = hkv_pkg::HASH_SEED;
      h = (h * 32'd33) ^ {24'd0, lo[7:0]};
      h = (h * 32'd33) ^ {24'd0, lo[15:8]};
      low_bytes[h] = lo[15:0];
    end
    inv33 = 32'd33;
    repeat (4) inv33 = inv33 * (32'd2 - 32'd33 * inv33);
    zero_found = 1'b0;
    zero_key   = '0;
    for (int hi = 0; hi < 65536 && !zero_found; hi++) begin
      h = (({24'd0, hi[15:8]} * inv33) ^ {24'd0, hi[7:0]}) * inv33;
      if (low_bytes.exists(h)) begin
        zero_key   = {hi[15:0], low_bytes[h]};
        zero_found = (map_model.raw_hash(zero_key) == 32'd0);
      end
    end

    while (fill_keys.size() < NSLOTS) begin
      k = $urandom;
      target = map_model.bucket_of(k);
      if (per_bucket[target] < NWAYS) begin
        fill_keys.push_back(k);
        per_bucket[target]++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(hkv_pkg::OP_LOOKUP, 32'h0000_0000, $urandom);
    send_request(hkv_pkg::OP_REMOVE, 32'hFFFF_FFFF, $urandom);
    send_request(hkv_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(hkv_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(hkv_pkg::OP_LOOKUP, 32'h0000_0000, $urandom);
    send_request(hkv_pkg::OP_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
    send_request(hkv_pkg::OP_REMOVE, 32'h0000_0000, $urandom);
    send_request(hkv_pkg::OP_LOOKUP, 32'h0000_0000, $urandom);
    for (int i = 0; i < 5; i++) send_request(hkv_pkg::OP_INSERT, group_keys[i], $urandom);
    send_request(hkv_pkg::OP_REMOVE, group_keys[1], $urandom);
    send_request(hkv_pkg::OP_INSERT, group_keys[4], $urandom);
    send_request(hkv_pkg::OP_LOOKUP, group_keys[4], $urandom);
    for (int i = 0; i < 4; i++) begin
      send_request(hkv_pkg::OP_INSERT, group_keys[GROUP_KEYS + i], $urandom);
    end
    if (zero_found) begin
      send_request(hkv_pkg::OP_INSERT, zero_key, $urandom);
    end else begin
      send_request(hkv_pkg::OP_LOOKUP, group_keys[GROUP_KEYS + 4], $urandom);
    end
    send_request(hkv_pkg::OP_CLEAR, $urandom, $urandom);
    send_request(hkv_pkg::OP_LOOKUP, group_keys[0], $urandom);

    // Fill every way of the table, then overflow it, look up and remove some keys, and clear it.
    foreach (fill_keys[i]) send_request(hkv_pkg::OP_INSERT, fill_keys[i], $urandom);
    send_request(hkv_pkg::OP_INSERT, $urandom, $urandom);
    repeat (8) begin
      send_request(hkv_pkg::OP_LOOKUP, fill_keys[$urandom_range(NSLOTS-1)], $urandom);
    end
    send_request(hkv_pkg::OP_REMOVE, fill_keys[$urandom_range(NSLOTS-1)], $urandom);
    send_request(hkv_pkg::OP_CLEAR, $urandom, $urandom);

    hold_go <= 1'b1;
    repeat (RANDOM_REQUESTS / 3) send_random_request();
    wait_results_drained();

    send_idle_pct = 45;
    recv_idle_pct <= 9;
    repeat (RANDOM_REQUESTS / 3) send_random_request();
    wait_results_drained();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    repeat (RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3)) send_random_request();
    wait_results_drained();
    repeat (NBUCKETS + 16) @(posedge clk_i);

    if (map_model.result_mismatches == 0 && map_model.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/hkv_pkg.sv
rtl/core/hkv_ram.sv
rtl/core/hkv_hash.sv
rtl/core/hkv_match.sv
rtl/core/hashed_key_value_map.sv
rtl/core/hkv_checker.sv
bench/hashed_key_value_map_test.sv
